// File: hw/rtl/tdtt_pkg.sv
package tdtt_pkg;

	localparam int SLOT_COUNT = 32;
	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CFG_W = 20;
	localparam logic [CFG_W-1:0] TIMEOUT_RESET = CFG_W'(20000);

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_POLL = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [2:0] KIND_EXPIRED = 3'd0;
	localparam logic [2:0] KIND_SUMMARY = 3'd1;
	localparam logic [2:0] KIND_STARTED = 3'd2;
	localparam logic [2:0] KIND_FULL = 3'd3;
	localparam logic [2:0] KIND_CANCELLED = 3'd4;

	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  timer_type;
		logic [19:0] delay_ms;
		logic [31:0] now_ms;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  expired_type;
		logic [19:0] next_timeout_ms;
		logic        last;
	} rsp_item_t;

	typedef struct packed {
		logic [3:0]  timer_type;
		logic [19:0] delay_ms;
		logic [31:0] start_ms;
	} slot_t;

	localparam int SLOT_DW = $bits(slot_t);

	typedef struct packed {
		logic load;
		logic adv;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic sweep_end;
	} dp_sts_t;

endpackage

// File: hw/rtl/tdtt_ram.sv
module tdtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/tdtt_ctrl.sv
module tdtt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic [1:0]         command,
	output logic               cmd_stall,
	input  tdtt_pkg::dp_sts_t  sts,
	output tdtt_pkg::ctl_cmd_t ctl
);
	import tdtt_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign cmd_stall = (state_q != ST_IDLE);
	assign ctl.load = cmd_valid && !cmd_stall && (command != CMD_UNUSED);
	assign ctl.adv = (state_q == ST_SWEEP) && sts.out_free;
	assign ctl.finish = (state_q == ST_DONE) && sts.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (ctl.load) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sts.sweep_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/tdtt_datapath.sv
module tdtt_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tdtt_pkg::ctl_cmd_t            ctl,
	output tdtt_pkg::dp_sts_t             sts,
	input  tdtt_pkg::cmd_item_t           cmd,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tdtt_pkg::CFG_W-1:0]    cfg_data,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output tdtt_pkg::rsp_item_t           rsp
);
	import tdtt_pkg::*;

	logic [CFG_W-1:0]      timeout_q;
	cmd_item_t             item_q;
	logic [SLOT_W:0]       rd_idx_q;
	logic                  valid_s1;
	logic [SLOT_W-1:0]     idx_s1;
	logic [SLOT_COUNT-1:0] pend_q;
	logic [19:0]           shortest_q;
	logic                  found_q;
	logic [SLOT_W-1:0]     claim_q;
	logic                  rsp_valid_q;
	rsp_item_t             rsp_q;

	logic                  rd_go;
	logic                  step;
	logic                  ram_we;
	slot_t                 wr_slot;
	logic [SLOT_DW-1:0]    ram_rdata;
	slot_t                 rd_slot;
	logic                  type_hit;
	logic                  pend_cur;
	logic [31:0]           elapsed;
	logic [32:0]           diff;
	logic                  expired;
	logic [19:0]           remaining;
	logic                  fire;
	rsp_item_t             final_item;
	rsp_item_t             fire_item;

	assign cfg_ready = 1'b1;

	assign rd_go = ctl.adv && (rd_idx_q < (SLOT_W + 1)'(SLOT_COUNT));
	assign step = ctl.adv && valid_s1;
	assign sts.out_free = !rsp_valid_q || !rsp_stall;
	assign sts.sweep_end = step && (idx_s1 == SLOT_W'(SLOT_COUNT - 1));

	assign ram_we = ctl.finish && (item_q.command == CMD_START) && found_q;
	assign wr_slot = '{timer_type: item_q.timer_type, delay_ms: item_q.delay_ms,
		start_ms: item_q.now_ms};

	tdtt_ram #(
		.WIDTH(SLOT_DW),
		.DEPTH(SLOT_COUNT)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(claim_q),
		.wdata(wr_slot),
		.re   (rd_go),
		.raddr(rd_idx_q[SLOT_W-1:0]),
		.rdata(ram_rdata)
	);

	assign rd_slot = slot_t'(ram_rdata);
	assign type_hit = (rd_slot.timer_type == item_q.timer_type);
	assign pend_cur = pend_q[idx_s1];
	assign elapsed = item_q.now_ms - rd_slot.start_ms;
	assign diff = {13'b0, rd_slot.delay_ms} - {1'b0, elapsed};
	assign expired = diff[32] || (diff == 33'd0);
	assign remaining = diff[19:0];
	assign fire = step && (item_q.command == CMD_POLL) && pend_cur && expired;

	always_comb begin
		final_item = '0;
		final_item.last = 1'b1;
		case (item_q.command)
			CMD_START: begin
				final_item.kind = found_q ? KIND_STARTED : KIND_FULL;
			end
			CMD_CANCEL: begin
				final_item.kind = KIND_CANCELLED;
			end
			CMD_POLL: begin
				final_item.kind = KIND_SUMMARY;
				final_item.next_timeout_ms = shortest_q;
			end
			default: begin
				final_item.kind = KIND_CANCELLED;
			end
		endcase
	end

	always_comb begin
		fire_item = '0;
		fire_item.kind = KIND_EXPIRED;
		fire_item.expired_type = rd_slot.timer_type;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= cmd;
		end
		if (rd_go) begin
			idx_s1 <= rd_idx_q[SLOT_W-1:0];
		end
		if (ctl.load) begin
			shortest_q <= timeout_q;
		end else if (step && (item_q.command == CMD_POLL) && pend_cur && !expired
			&& (remaining < shortest_q)) begin
			shortest_q <= remaining;
		end
		if (step && (item_q.command == CMD_START) && !found_q
			&& (!pend_cur || type_hit)) begin
			claim_q <= idx_s1;
		end
		if (fire) begin
			rsp_q <= fire_item;
		end else if (ctl.finish) begin
			rsp_q <= final_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
			found_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				rd_idx_q <= '0;
			end else if (rd_go) begin
				rd_idx_q <= rd_idx_q + (SLOT_W + 1)'(1);
			end
			if (ctl.load) begin
				valid_s1 <= 1'b0;
			end else if (ctl.adv) begin
				valid_s1 <= rd_go;
			end
			if (ctl.load) begin
				found_q <= 1'b0;
			end else if (step && (item_q.command == CMD_START)
				&& (!pend_cur || type_hit)) begin
				found_q <= 1'b1;
			end
			if (fire || ctl.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			if (step && pend_cur) begin
				case (item_q.command)
					CMD_START, CMD_CANCEL: begin
						if (type_hit) begin
							pend_q[idx_s1] <= 1'b0;
						end
					end
					CMD_POLL: begin
						if (expired) begin
							pend_q[idx_s1] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			if (ram_we) begin
				pend_q[claim_q] <= 1'b1;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

// File: hw/rtl/typed_delay_timer_table_unit.sv
// Every start, cancel or poll sweeps the slot table through a RAM with separate read and
// write ports, one slot per cycle while the output is not stalled; new commands wait.
// An expired slot goes from the RAM read register to the output register; the final
// result is registered after the sweep once the output frees. Unused codes are ignored.
// Reset clears every pending bit and loads the default timeout of 20000 ms; slot
// contents are not cleared and need no clearing pass.
module typed_delay_timer_table_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  tdtt_pkg::cmd_item_t        cmd,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output tdtt_pkg::rsp_item_t        rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tdtt_pkg::CFG_W-1:0] cfg_data
);
	import tdtt_pkg::*;

	ctl_cmd_t ctl;
	dp_sts_t  sts;

	tdtt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.command  (cmd.command),
		.cmd_stall(cmd_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	tdtt_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.cmd      (cmd),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

`ifndef SYNTH
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> cmd_stall)
		else $error("Input not stalled after a command transfer.");

	a_finish_gives_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |=> (rsp_valid && rsp.last))
		else $error("Closing result missing after the sweep.");

	a_expired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.kind == KIND_EXPIRED)) |-> !rsp.last)
		else $error("Expiry result flagged as last.");

	a_no_sweep_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.adv || ctl.finish) |-> cmd_stall)
		else $error("Datapath stepped while the block was idle.");
`endif

endmodule
